### sv/clock_page_replacement_mmu_defines.svh
// Assertion macros shared by the clock page replacement MMU modules.
// No dependencies; included by the controller and the datapath.
`ifndef CLOCK_PAGE_REPLACEMENT_MMU_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_MMU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/cpr_pkg.sv
// Shared types and constants of the clock page replacement MMU.
// No dependencies; used by the interfaces, controller, datapath and top level.
package cpr_pkg;

	localparam int PID_W          = 3;
	localparam int PAGE_W         = 6;
	localparam int FRAME_NUMBER_W = 4;

	// Owner record of one physical frame (the valid bit lives in flops).
	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [PAGE_W-1:0] page;
	} cpr_owner_t;

	localparam int OWNER_W = $bits(cpr_owner_t);

	typedef struct packed {
		logic [FRAME_NUMBER_W-1:0] frame_number;
		logic                      page_fault;
		logic                      evicted_valid;
		logic [PID_W-1:0]          evicted_process;
		logic [PAGE_W-1:0]         evicted_page;
		logic                      evicted_dirty;
	} cpr_result_t;

	// Page table write operations.
	typedef enum logic [2:0] {
		PT_NONE  = 3'd0,
		PT_CLEAR = 3'd1,
		PT_HIT   = 3'd2,
		PT_EVICT = 3'd3,
		PT_MAP   = 3'd4
	} cpr_pt_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_in;
		logic       pt_rd_old;
		cpr_pt_op_t pt_op;
		logic       sweep;
		logic       ev_capture;
	} cpr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic hit;
		logic ref_set;
		logic owner_valid;
		logic out_free;
	} cpr_sts_t;

endpackage

### sv/cpr_req_if.sv
// Request channel interface: one memory access per transfer.
// Depends on cpr_pkg for the field widths.
interface cpr_req_if;
	logic                       valid;
	logic                       ready;
	logic [cpr_pkg::PID_W-1:0]  process_id;
	logic [cpr_pkg::PAGE_W-1:0] page_number;
	logic                       is_write;

	modport source (output valid, output process_id, output page_number, output is_write,
		input ready);
	modport sink (input valid, input process_id, input page_number, input is_write,
		output ready);
endinterface

### sv/cpr_rsp_if.sv
// Response channel interface: one translation result per transfer.
// Depends on cpr_pkg for the field widths.
interface cpr_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [cpr_pkg::FRAME_NUMBER_W-1:0] frame_number;
	logic                               page_fault;
	logic                               evicted_valid;
	logic [cpr_pkg::PID_W-1:0]          evicted_process;
	logic [cpr_pkg::PAGE_W-1:0]         evicted_page;
	logic                               evicted_dirty;

	modport source (output valid, output frame_number, output page_fault,
		output evicted_valid, output evicted_process, output evicted_page,
		output evicted_dirty, input ready);
	modport sink (input valid, input frame_number, input page_fault,
		input evicted_valid, input evicted_process, input evicted_page,
		input evicted_dirty, output ready);
endinterface

### sv/clock_page_replacement_mmu.sv
// Top level of the clock (second chance) page replacement MMU.
// Depends on cpr_pkg, cpr_req_if, cpr_rsp_if, cpr_ctrl and cpr_datapath.
//
//   channel | modport | per transfer
//   --------+---------+---------------------------------------------------------
//   req     | sink    | process_id, page_number, is_write
//   rsp     | source  | frame_number, page_fault, evicted_valid/process/page/dirty
//
// A hit passes through capture, page table read and write back; a fault through
// capture, read, lookup, the sweep, owner read and check, an eviction read if the
// frame is owned, and mapping. The sweep tests one frame per cycle, clearing each
// set reference bit it passes. After reset the page table is cleared one entry per
// cycle, all PROCESSES * PAGES_PER_PROCESS of them, before requests are accepted.
// A finished result waits in the output register; the block holds its last step
// only while that register is still full and not being drained.
module clock_page_replacement_mmu #(
	parameter int FRAMES            = 16,
	parameter int PROCESSES         = 8,
	parameter int PAGES_PER_PROCESS = 64
) (
	input logic       clk,
	input logic       arst_n,
	cpr_req_if.sink   req,
	cpr_rsp_if.source rsp
);
	import cpr_pkg::*;

	// The controller and datapath talk only through these two groups.
	cpr_cmd_t    cmd;
	cpr_sts_t    sts;
	cpr_result_t result;
	logic        result_valid;

	// The controller sequences one request at a time: it accepts a transfer only
	// when idle, then walks lookup, sweep, eviction and mapping steps.
	cpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the page table, owner records, reference bits,
	// clock hand and the output register.
	cpr_datapath #(
		.FRAMES            (FRAMES),
		.PROCESSES         (PROCESSES),
		.PAGES_PER_PROCESS (PAGES_PER_PROCESS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.process_id   (req.process_id),
		.page_number  (req.page_number),
		.is_write     (req.is_write),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (rsp.ready)
	);

	assign rsp.valid           = result_valid;
	assign rsp.frame_number    = result.frame_number;
	assign rsp.page_fault      = result.page_fault;
	assign rsp.evicted_valid   = result.evicted_valid;
	assign rsp.evicted_process = result.evicted_process;
	assign rsp.evicted_page    = result.evicted_page;
	assign rsp.evicted_dirty   = result.evicted_dirty;
endmodule

### sv/cpr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### sv/cpr_ctrl.sv
// Sequencer of the clock page replacement MMU: page table clear, lookup,
// clock sweep, eviction and mapping. Depends on cpr_pkg and the defines header.
`include "clock_page_replacement_mmu_defines.svh"

module cpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cpr_pkg::cpr_sts_t sts,
	output cpr_pkg::cpr_cmd_t cmd
);
	import cpr_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR   = 9'b000000001,
		ST_IDLE    = 9'b000000010,
		ST_READ    = 9'b000000100,
		ST_LOOKUP  = 9'b000001000,
		ST_SWEEP   = 9'b000010000,
		ST_OWN_RD  = 9'b000100000,
		ST_OWN_CHK = 9'b001000000,
		ST_EV_RD   = 9'b010000000,
		ST_MAP     = 9'b100000000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx       = state_q;
		cmd            = '0;
		cmd.pt_op      = PT_NONE;
		req_ready      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.pt_op = PT_CLEAR;
				if (sts.clear_done) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_nx    = ST_READ;
				end
			end
			ST_READ: begin
				state_nx = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (sts.hit) begin
					if (sts.out_free) begin
						cmd.pt_op = PT_HIT;
						state_nx  = ST_IDLE;
					end
				end else begin
					state_nx = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (!sts.ref_set) begin
					state_nx = ST_OWN_RD;
				end
			end
			ST_OWN_RD: begin
				state_nx = ST_OWN_CHK;
			end
			ST_OWN_CHK: begin
				cmd.ev_capture = 1'b1;
				cmd.pt_rd_old  = 1'b1;
				state_nx       = sts.owner_valid ? ST_EV_RD : ST_MAP;
			end
			ST_EV_RD: begin
				cmd.pt_op = PT_EVICT;
				state_nx  = ST_MAP;
			end
			ST_MAP: begin
				if (sts.out_free) begin
					cmd.pt_op = PT_MAP;
					state_nx  = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	`CPR_ASSERT_NEXT(a_accept_reads, clk, arst_n, req_valid && req_ready, state_q == ST_READ)
	`CPR_ASSERT_NEXT(a_no_owner_maps, clk, arst_n, (state_q == ST_OWN_CHK) && !sts.owner_valid, state_q == ST_MAP)
	`CPR_ASSERT_NEXT(a_hit_waits, clk, arst_n, (state_q == ST_LOOKUP) && sts.hit && !sts.out_free, state_q == ST_LOOKUP)
endmodule

### sv/cpr_datapath.sv
// Datapath of the clock page replacement MMU: page table and owner RAMs,
// reference bits, clock hand, eviction record and result register.
// Depends on cpr_pkg, cpr_ram and the defines header.
`include "clock_page_replacement_mmu_defines.svh"

module cpr_datapath #(
	parameter int FRAMES            = 16,
	parameter int PROCESSES         = 8,
	parameter int PAGES_PER_PROCESS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cpr_pkg::cpr_cmd_t          cmd,
	output cpr_pkg::cpr_sts_t          sts,
	input  logic [cpr_pkg::PID_W-1:0]  process_id,
	input  logic [cpr_pkg::PAGE_W-1:0] page_number,
	input  logic                       is_write,
	output cpr_pkg::cpr_result_t       result,
	output logic                       result_valid,
	input  logic                       result_ready
);
	import cpr_pkg::*;

	localparam int KEYS = PROCESSES * PAGES_PER_PROCESS;
	localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int FW   = $clog2(FRAMES);

	typedef logic [KW-1:0] key_t;
	typedef logic [FW-1:0] frame_t;

	typedef struct packed {
		logic   present;
		frame_t frame;
		logic   dirty;
	} pte_t;

	localparam int PTE_W = $bits(pte_t);

	// Modulo reduction of the request fields as constant tables.
	logic [PID_W-1:0]  pid_mod  [2**PID_W];
	logic [PAGE_W-1:0] page_mod [2**PAGE_W];

	for (genvar i = 0; i < 2**PID_W; i++) begin : g_pid_mod
		assign pid_mod[i] = PID_W'(i % PROCESSES);
	end
	for (genvar i = 0; i < 2**PAGE_W; i++) begin : g_page_mod
		assign page_mod[i] = PAGE_W'(i % PAGES_PER_PROCESS);
	end

	function automatic key_t key_of(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
		key_of = key_t'(pid) * key_t'(PAGES_PER_PROCESS) + key_t'(page);
	endfunction

	function automatic logic [PTE_W-1:0] pt_wdata_from(pte_t e);
		pt_wdata_from = e;
	endfunction

	logic [PID_W-1:0]  pid_q;
	logic [PAGE_W-1:0] page_q;
	logic              wr_q;
	key_t              key_q;
	key_t              old_key_q;
	key_t              clr_q;
	frame_t            hand_q;
	frame_t            victim_q;
	frame_t            hand_nx;
	logic [FRAMES-1:0] ref_q;
	logic [FRAMES-1:0] own_valid_q;
	logic              ev_valid_q;
	logic [PID_W-1:0]  ev_pid_q;
	logic [PAGE_W-1:0] ev_page_q;
	logic              ev_dirty_q;
	cpr_result_t       result_q;
	logic              result_valid_q;

	logic [PTE_W-1:0]   pt_rdata;
	logic [PTE_W-1:0]   pt_wdata;
	key_t               pt_waddr;
	key_t               pt_raddr;
	logic               pt_we;
	pte_t               pte_rd;
	pte_t               pte_wr;
	logic [OWNER_W-1:0] own_rdata;
	cpr_owner_t         own_rd;
	cpr_owner_t         own_wr;

	assign pte_rd = pte_t'(pt_rdata);
	assign own_rd = cpr_owner_t'(own_rdata);
	assign own_wr = '{pid: pid_q, page: page_q};

	assign hand_nx = (hand_q == frame_t'(FRAMES - 1)) ? '0 : hand_q + 1'b1;

	// Page table write port.
	always_comb begin
		pt_we    = 1'b1;
		pt_waddr = key_q;
		pte_wr   = '0;
		unique case (cmd.pt_op)
			PT_NONE: begin
				pt_we = 1'b0;
			end
			PT_CLEAR: begin
				pt_waddr = clr_q;
			end
			PT_HIT: begin
				pte_wr = '{present: 1'b1, frame: pte_rd.frame, dirty: pte_rd.dirty | wr_q};
			end
			PT_EVICT: begin
				pt_waddr = old_key_q;
			end
			PT_MAP: begin
				pte_wr = '{present: 1'b1, frame: victim_q, dirty: wr_q};
			end
			default: begin
				pt_we = 1'b0;
			end
		endcase
	end

	assign pt_wdata = pt_wdata_from(pte_wr);
	assign pt_raddr = cmd.pt_rd_old ? key_of(own_rd.pid, own_rd.page) : key_q;

	cpr_ram #(.WIDTH(PTE_W), .DEPTH(KEYS)) u_page_table (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	cpr_ram #(.WIDTH(OWNER_W), .DEPTH(FRAMES)) u_owner (
		.clk   (clk),
		.we    (cmd.pt_op == PT_MAP),
		.waddr (victim_q),
		.wdata (own_wr),
		.raddr (victim_q),
		.rdata (own_rdata)
	);

	// Request capture, eviction record, victim choice and result register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pid_q  <= pid_mod[process_id];
			page_q <= page_mod[page_number];
			wr_q   <= is_write;
			key_q  <= key_of(pid_mod[process_id], page_mod[page_number]);
		end
		if (cmd.ev_capture) begin
			ev_valid_q <= own_valid_q[victim_q];
			ev_pid_q   <= own_valid_q[victim_q] ? own_rd.pid : '0;
			ev_page_q  <= own_valid_q[victim_q] ? own_rd.page : '0;
			ev_dirty_q <= 1'b0;
			old_key_q  <= key_of(own_rd.pid, own_rd.page);
		end
		if (cmd.pt_op == PT_EVICT) begin
			ev_dirty_q <= pte_rd.dirty;
		end
		if (cmd.sweep && !ref_q[hand_q]) begin
			victim_q <= hand_q;
		end
		if (cmd.pt_op == PT_HIT) begin
			result_q <= '{frame_number: FRAME_NUMBER_W'(pte_rd.frame), page_fault: 1'b0,
				evicted_valid: 1'b0, evicted_process: '0, evicted_page: '0,
				evicted_dirty: 1'b0};
		end else if (cmd.pt_op == PT_MAP) begin
			result_q <= '{frame_number: FRAME_NUMBER_W'(victim_q), page_fault: 1'b1,
				evicted_valid: ev_valid_q, evicted_process: ev_pid_q,
				evicted_page: ev_page_q, evicted_dirty: ev_dirty_q};
		end
	end

	// Control state: clock hand, reference and owner valid bits, clear counter and result valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q         <= '0;
			ref_q          <= '0;
			own_valid_q    <= '0;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.pt_op == PT_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.sweep) begin
				hand_q <= hand_nx;
				if (ref_q[hand_q]) begin
					ref_q[hand_q] <= 1'b0;
				end
			end
			if (cmd.pt_op == PT_HIT) begin
				ref_q[pte_rd.frame] <= 1'b1;
			end
			if (cmd.pt_op == PT_MAP) begin
				ref_q[victim_q]       <= 1'b1;
				own_valid_q[victim_q] <= 1'b1;
			end
			if ((cmd.pt_op == PT_HIT) || (cmd.pt_op == PT_MAP)) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_done  = (clr_q == key_t'(KEYS - 1));
	assign sts.hit         = pte_rd.present;
	assign sts.ref_set     = ref_q[hand_q];
	assign sts.owner_valid = own_valid_q[victim_q];
	assign sts.out_free    = !result_valid_q || result_ready;

	assign result       = result_q;
	assign result_valid = result_valid_q;

	`CPR_ASSERT_NEXT(a_sweep_victim, clk, arst_n, cmd.sweep && !ref_q[hand_q], victim_q == $past(hand_q))
	`CPR_ASSERT_NEXT(a_map_marks, clk, arst_n, cmd.pt_op == PT_MAP, ref_q[victim_q] && own_valid_q[victim_q] && result_valid_q)
	`CPR_ASSERT_SAME(a_hit_out_free, clk, arst_n, cmd.pt_op == PT_HIT, sts.out_free && pte_rd.present)
endmodule

### tb/clock_page_replacement_mmu_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the clock page replacement MMU top level.
// Depends on cpr_pkg, cpr_req_if, cpr_rsp_if and clock_page_replacement_mmu.

// Keeps a copy of the page table, the frame owners, the reference bits and the
// clock hand. It turns each accepted access into the translation it must
// produce, and it checks every translation that the block hands back.
class translation_tracker;
	localparam int FRAME_COUNT = 16;
	localparam int KEY_COUNT   = 512;

	bit                                  page_present [KEY_COUNT];
	bit [cpr_pkg::FRAME_NUMBER_W-1:0]    page_frame [KEY_COUNT];
	bit                                  page_dirty [KEY_COUNT];
	bit                                  frame_owned [FRAME_COUNT];
	bit [cpr_pkg::OWNER_W-1:0]           frame_owner [FRAME_COUNT];
	bit [FRAME_COUNT-1:0]                referenced;
	bit [cpr_pkg::FRAME_NUMBER_W-1:0]    hand;
	cpr_pkg::cpr_result_t                pending_translations [$];
	int                                  failures;

	// Works out the translation of one access and updates the tables.
	function void note_access(bit [cpr_pkg::PID_W-1:0] pid,
		bit [cpr_pkg::PAGE_W-1:0] page, bit wr);
		bit [cpr_pkg::OWNER_W-1:0]        key;
		bit [cpr_pkg::OWNER_W-1:0]        victim;
		bit [cpr_pkg::FRAME_NUMBER_W-1:0] frame;
		cpr_pkg::cpr_result_t             translation;
		int                               steps;
		key = {pid, page};
		translation = '0;
		if (page_present[key]) begin
			frame = page_frame[key];
		end else begin
			translation.page_fault = 1'b1;
			// Second chance: pass over referenced frames, clearing their bits.
			frame = hand;
			for (steps = 0; steps < FRAME_COUNT && referenced[frame]; steps++) begin
				referenced[frame] = 1'b0;
				frame = frame + 1'b1;
			end
			hand = frame + 1'b1;
			if (frame_owned[frame]) begin
				victim = frame_owner[frame];
				translation.evicted_valid   = 1'b1;
				translation.evicted_process = victim[cpr_pkg::OWNER_W-1:cpr_pkg::PAGE_W];
				translation.evicted_page    = victim[cpr_pkg::PAGE_W-1:0];
				translation.evicted_dirty   = page_dirty[victim];
				page_present[victim] = 1'b0;
				page_dirty[victim]   = 1'b0;
				page_frame[victim]   = '0;
			end
			page_present[key]  = 1'b1;
			page_frame[key]    = frame;
			page_dirty[key]    = 1'b0;
			frame_owned[frame] = 1'b1;
			frame_owner[frame] = key;
		end
		referenced[frame] = 1'b1;
		if (wr)
			page_dirty[key] = 1'b1;
		translation.frame_number = frame;
		pending_translations.push_back(translation);
	endfunction

	function void compare_field(string name, int expected, int actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
			failures++;
		end
	endfunction

	// Compares a returned translation with the oldest one still owed.
	function void check_result(cpr_pkg::cpr_result_t got);
		cpr_pkg::cpr_result_t owed;
		if (pending_translations.size() == 0) begin
			$error("translation returned with none outstanding (frame %0d)",
				got.frame_number);
			failures++;
			return;
		end
		owed = pending_translations.pop_front();
		compare_field("frame_number", owed.frame_number, got.frame_number);
		compare_field("page_fault", owed.page_fault, got.page_fault);
		compare_field("evicted_valid", owed.evicted_valid, got.evicted_valid);
		compare_field("evicted_process", owed.evicted_process, got.evicted_process);
		compare_field("evicted_page", owed.evicted_page, got.evicted_page);
		compare_field("evicted_dirty", owed.evicted_dirty, got.evicted_dirty);
	endfunction
endclass

module clock_page_replacement_mmu_tb;
	import cpr_pkg::*;

	// The block clears its 512-entry page table after reset before it takes a
	// request, and the receiver holds off once for HOLD_OFF_CYCLES. The
	// watchdog limit is several times the longest quiet stretch of a good run.
	localparam int FRAMES          = 16;
	localparam int RANDOM_ACCESSES = 1030;
	localparam int CALM_TAIL       = 100;
	localparam int HOLD_OFF_AT     = 300;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int POOL_SIZE       = 24;
	localparam int DRAIN_CYCLES    = 40;
	localparam int STALL_LIMIT     = 4000;

	logic clk;
	logic arst_n;

	cpr_req_if req_ch ();
	cpr_rsp_if rsp_ch ();

	translation_tracker tracker;

	// Set by the stimulus: no idling from here on, and a request for the one
	// long hold-off on the response side.
	bit calm_tail;
	bit hold_off_request;
	bit sender_bursty;
	int stalled_cycles;

	clock_page_replacement_mmu #(
		.FRAMES            (FRAMES),
		.PROCESSES         (8),
		.PAGES_PER_PROCESS (64)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one access and waits for the transfer. Valid is left high so that
	// back-to-back accesses keep it asserted; idle_sender lowers it.
	task automatic send_access(bit [PID_W-1:0] pid, bit [PAGE_W-1:0] page, bit wr);
		req_ch.valid       <= 1'b1;
		req_ch.process_id  <= pid;
		req_ch.page_number <= page;
		req_ch.is_write    <= wr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_access(pid, page, wr);
	endtask

	task automatic idle_sender(int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Random gaps on the request side, in bursts, except in quiet stretches
	// and in the calm tail of the run.
	task automatic maybe_idle();
		if (!calm_tail && sender_bursty && $urandom_range(0, 5) == 0)
			idle_sender($urandom_range(1, 19));
	endtask

	// Response side: ready runs high for random stretches with random idle bursts
	// between them. The single long hold-off lets the block fill up and push back on
	// the request side while accesses keep coming.
	initial begin
		int run_length;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				run_length = $urandom_range(1, 60);
				rsp_ch.ready <= 1'b1;
				repeat (run_length) @(posedge clk);
			end
		end
	end

	// Every response transfer is checked against the oldest owed translation.
	always @(posedge clk) begin
		cpr_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.frame_number    = rsp_ch.frame_number;
			got.page_fault      = rsp_ch.page_fault;
			got.evicted_valid   = rsp_ch.evicted_valid;
			got.evicted_process = rsp_ch.evicted_process;
			got.evicted_page    = rsp_ch.evicted_page;
			got.evicted_dirty   = rsp_ch.evicted_dirty;
			tracker.check_result(got);
		end
	end

	// Watchdog: too long without any transfer on either channel means a hang.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		bit [PID_W-1:0]   pool_pid [POOL_SIZE];
		bit [PAGE_W-1:0]  pool_page [POOL_SIZE];
		bit [PID_W-1:0]   pid;
		bit [PAGE_W-1:0]  page;
		int               pick;
		tracker = new;
		arst_n = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.process_id  = '0;
		req_ch.page_number = '0;
		req_ch.is_write    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		sender_bursty = 1'b1;

		// Directed part. Sixteen distinct pages fill every frame, with every
		// process number and the lowest and highest page; odd ones are writes.
		for (int i = 0; i < FRAMES; i++) begin
			maybe_idle();
			send_access(i[2:0], i[3] ? 6'd63 : 6'd0, i[0]);
		end
		// Read hit on a dirty page: no fault, nothing evicted.
		send_access(3'd7, 6'd63, 1'b0);
		// Every reference bit is now set, so this fault sweeps the whole ring,
		// comes back to frame 0 and evicts its clean owner.
		send_access(3'd3, 6'd21, 1'b1);
		// The hand moved on; this fault takes frame 1 and evicts a dirty page.
		send_access(3'd5, 6'd42, 1'b0);
		// Write hit on the page that took frame 0.
		send_access(3'd3, 6'd21, 1'b1);
		// The page evicted first comes back and displaces another.
		send_access(3'd0, 6'd0, 1'b0);
		send_access(3'd0, 6'd0, 1'b1);

		// Random part. Most accesses come from a small working set so that
		// hits, second chances and evictions of dirty pages all happen often;
		// the set is redrawn now and then, and the rest is spread over the
		// whole address space.
		for (int n = 0; n < RANDOM_ACCESSES; n++) begin
			if (n % 200 == 0) begin
				for (int k = 0; k < POOL_SIZE; k++) begin
					pool_pid[k]  = PID_W'($urandom_range(0, 7));
					pool_page[k] = PAGE_W'($urandom_range(0, 63));
				end
			end
			if (n % 64 == 0)
				sender_bursty = $urandom_range(0, 2) != 0;
			if (n == HOLD_OFF_AT)
				hold_off_request = 1'b1;
			if (n == RANDOM_ACCESSES - CALM_TAIL)
				calm_tail = 1'b1;
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, POOL_SIZE - 1);
				pid  = pool_pid[pick];
				page = pool_page[pick];
			end else begin
				pid  = PID_W'($urandom_range(0, 7));
				page = PAGE_W'($urandom_range(0, 63));
			end
			maybe_idle();
			send_access(pid, page, 1'($urandom_range(0, 1)));
		end
		req_ch.valid <= 1'b0;

		// Wait for every owed translation, then a little longer so that any
		// stray extra response is caught. The watchdog bounds the wait.
		while (tracker.pending_translations.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
